// ===== hw/rtl/multi_channel_byte_pipe_defines.svh =====
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe defines
// assertion macros shared by the byte pipe design
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BYTE_PIPE_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_PIPE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MCBP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MCBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbp_pkg
// types and codes shared by the byte pipe front, queue and back
// ----------------------------------------------------------------------------
package mcbp_pkg;

    localparam int unsigned LEN_W = 9;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PIPE_NUM_W = 4;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_PIPE     = 3'd1,
        ST_NOT_OPEN     = 3'd2,
        ST_OPEN_REFUSED = 3'd3,
        ST_FULL         = 3'd4,
        ST_EMPTY        = 3'd5
    } status_t;

    // classified request as it travels from front to back
    typedef struct packed {
        op_t                   op;
        logic [PIPE_NUM_W-1:0] pipe;
        logic [LEN_W-1:0]      length;
        logic [BYTE_W-1:0]     data;
        logic                  bad_pipe;
        logic                  len_ok;
    } req_t;

    // queue status seen by the front and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hw/rtl/mcbp_queue.sv =====
// ----------------------------------------------------------------------------
// mcbp_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module mcbp_queue
    import mcbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  req_t    push_req,
    input  logic    pop,
    output req_t    head_req,
    output q_stat_t stat
);

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign head_req   = slot_reg[rd_ptr_reg];
    assign stat.full  = count_reg[1];
    assign stat.empty = (count_reg == 2'd0);

endmodule

// ===== hw/rtl/mcbp_front.sv =====
// ----------------------------------------------------------------------------
// mcbp_front
// accepts requests and classifies pipe number and open length
// ----------------------------------------------------------------------------
module mcbp_front
    import mcbp_pkg::*;
#(
    parameter int unsigned NUM_PIPES  = 8,
    parameter int unsigned PIPE_BYTES = 256
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [PIPE_NUM_W-1:0] s_pipe,
    input  logic [LEN_W-1:0]      s_length,
    input  logic [BYTE_W-1:0]     s_data_in,
    input  q_stat_t               q_stat,
    output logic                  q_push,
    output req_t                  q_req
);

    always_comb begin
        s_ready         = ~q_stat.full;
        q_push          = s_valid & s_ready;
        q_req.op        = op_t'(s_operation);
        q_req.pipe      = s_pipe;
        q_req.length    = s_length;
        q_req.data      = s_data_in;
        // pipe numbers past the configured count are rejected outright
        q_req.bad_pipe  = ({1'b0, s_pipe} >= (PIPE_NUM_W + 1)'(NUM_PIPES));
        // usable open capacity is 1 .. PIPE_BYTES
        q_req.len_ok    = (s_length != '0) && (s_length <= LEN_W'(PIPE_BYTES));
    end

endmodule

// ===== hw/rtl/mcbp_back.sv =====
// ----------------------------------------------------------------------------
// mcbp_back
// per-pipe state, ring storage and result register
// ----------------------------------------------------------------------------
module mcbp_back
    import mcbp_pkg::*;
#(
    parameter int unsigned NUM_PIPES  = 8,
    parameter int unsigned PIPE_BYTES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  req_t              head_req,
    output logic              head_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [BYTE_W-1:0] m_data_out,
    output logic [LEN_W-1:0]  m_fill_count,
    output logic [LEN_W-1:0]  m_capacity,
    output logic              m_can_write,
    output logic              m_can_read
);

    localparam int unsigned PIPE_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int unsigned POS_W     = $clog2(PIPE_BYTES);
    localparam int unsigned MEM_DEPTH = NUM_PIPES * PIPE_BYTES;
    localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] PIPE_STRIDE = ADDR_W'(PIPE_BYTES);

    // per-pipe state
    logic [LEN_W-1:0] fill_reg [NUM_PIPES];
    logic [LEN_W-1:0] cap_reg  [NUM_PIPES];
    logic [POS_W-1:0] wpos_reg [NUM_PIPES];
    logic [POS_W-1:0] rpos_reg [NUM_PIPES];
    logic             open_reg [NUM_PIPES];

    logic [BYTE_W-1:0] ring_mem [MEM_DEPTH];

    logic [PIPE_W-1:0] p_idx;
    logic [LEN_W-1:0]  fill_cur;
    logic [LEN_W-1:0]  cap_cur;
    logic [POS_W-1:0]  wpos_cur;
    logic [POS_W-1:0]  rpos_cur;
    logic              open_cur;
    logic [LEN_W-1:0]  fill_next;
    logic [LEN_W-1:0]  cap_next;
    logic [POS_W-1:0]  wpos_next;
    logic [POS_W-1:0]  rpos_next;
    logic              open_next;
    logic [LEN_W-1:0]  wpos_inc;
    logic [LEN_W-1:0]  rpos_inc;
    logic [LEN_W-1:0]  free_space;
    logic              state_upd;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    status_t           st;
    logic [LEN_W-1:0]  res_fill;
    logic [LEN_W-1:0]  res_cap;
    logic              res_cw;
    logic              res_cr;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    logic              pop_hit_reg;
    logic [LEN_W-1:0]  fill_out_reg;
    logic [LEN_W-1:0]  cap_out_reg;
    logic              cw_reg;
    logic              cr_reg;
    logic [BYTE_W-1:0] rdata_reg;

    assign p_idx    = head_req.pipe[PIPE_W-1:0];
    assign fill_cur = fill_reg[p_idx];
    assign cap_cur  = cap_reg[p_idx];
    assign wpos_cur = wpos_reg[p_idx];
    assign rpos_cur = rpos_reg[p_idx];
    assign open_cur = open_reg[p_idx];

    assign head_pop = head_valid & (~out_valid_reg | m_ready);
    assign wpos_inc = LEN_W'(wpos_cur) + LEN_W'(1);
    assign rpos_inc = LEN_W'(rpos_cur) + LEN_W'(1);

    always_comb begin
        st        = ST_OK;
        state_upd = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        fill_next = fill_cur;
        cap_next  = cap_cur;
        wpos_next = wpos_cur;
        rpos_next = rpos_cur;
        open_next = open_cur;
        if (head_req.bad_pipe) begin
            st = ST_BAD_PIPE;
        end else begin
            case (head_req.op)
                OP_OPEN: begin
                    if (!head_req.len_ok || open_cur) begin
                        st = ST_OPEN_REFUSED;
                    end else begin
                        state_upd = 1'b1;
                        fill_next = '0;
                        cap_next  = head_req.length;
                        wpos_next = '0;
                        rpos_next = '0;
                        open_next = 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (!open_cur) begin
                        st = ST_NOT_OPEN;
                    end else if (fill_cur >= cap_cur) begin
                        st = ST_FULL;
                    end else begin
                        state_upd = 1'b1;
                        mem_we    = 1'b1;
                        fill_next = fill_cur + LEN_W'(1);
                        wpos_next = (wpos_inc >= cap_cur) ? '0 : wpos_inc[POS_W-1:0];
                    end
                end
                OP_POP: begin
                    if (!open_cur) begin
                        st = ST_NOT_OPEN;
                    end else if (fill_cur == '0) begin
                        st = ST_EMPTY;
                    end else begin
                        state_upd = 1'b1;
                        mem_re    = 1'b1;
                        fill_next = fill_cur - LEN_W'(1);
                        rpos_next = (rpos_inc >= cap_cur) ? '0 : rpos_inc[POS_W-1:0];
                    end
                end
                default: begin
                    if (!open_cur) begin
                        st = ST_NOT_OPEN;
                    end
                end
            endcase
        end

        // flags are taken against the state after the request
        free_space = cap_next - fill_next;
        if (!head_req.bad_pipe && open_next) begin
            res_fill = fill_next;
            res_cap  = cap_next;
            res_cw   = (free_space >= head_req.length);
            res_cr   = (fill_next >= head_req.length);
        end else begin
            res_fill = '0;
            res_cap  = '0;
            res_cw   = 1'b0;
            res_cr   = 1'b0;
        end

        mem_addr = ADDR_W'(p_idx) * PIPE_STRIDE
                 + ADDR_W'(mem_we ? wpos_cur : rpos_cur);

        out_valid_next = head_pop | (out_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                fill_reg[i] <= '0;
                cap_reg[i]  <= '0;
                wpos_reg[i] <= '0;
                rpos_reg[i] <= '0;
                open_reg[i] <= 1'b0;
            end
        end else if (head_pop && state_upd) begin
            fill_reg[p_idx] <= fill_next;
            cap_reg[p_idx]  <= cap_next;
            wpos_reg[p_idx] <= wpos_next;
            rpos_reg[p_idx] <= rpos_next;
            open_reg[p_idx] <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop && mem_we) begin
            ring_mem[mem_addr] <= head_req.data;
        end
        if (head_pop && mem_re) begin
            rdata_reg <= ring_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            status_reg   <= st;
            pop_hit_reg  <= mem_re;
            fill_out_reg <= res_fill;
            cap_out_reg  <= res_cap;
            cw_reg       <= res_cw;
            cr_reg       <= res_cr;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_data_out   = pop_hit_reg ? rdata_reg : '0;
    assign m_fill_count = fill_out_reg;
    assign m_capacity   = cap_out_reg;
    assign m_can_write  = cw_reg;
    assign m_can_read   = cr_reg;

endmodule

// ===== hw/rtl/multi_channel_byte_pipe.sv =====
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe
// path: a request accepted by the front is written into a queue slot and
// moves into the result register of the back once the result side is free
// throughput: one request per cycle while results are taken, set by the
// single-port ring storage and the back's per-pipe state update, once per request
// reset: pipe flags, counts, capacities and positions clear at once;
// ring storage is not cleared and is only read where a push wrote it
// ----------------------------------------------------------------------------
`include "multi_channel_byte_pipe_defines.svh"

module multi_channel_byte_pipe
    import mcbp_pkg::*;
#(
    parameter int unsigned NUM_PIPES  = 8,
    parameter int unsigned PIPE_BYTES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [PIPE_NUM_W-1:0] s_pipe,
    input  logic [LEN_W-1:0]      s_length,
    input  logic [BYTE_W-1:0]     s_data_in,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [BYTE_W-1:0]     m_data_out,
    output logic [LEN_W-1:0]      m_fill_count,
    output logic [LEN_W-1:0]      m_capacity,
    output logic                  m_can_write,
    output logic                  m_can_read
);

    // front to queue
    logic    q_push;
    req_t    q_req;
    q_stat_t q_stat;
    // queue to back
    req_t    head_req;
    logic    head_pop;

    // front: takes a request whenever the queue has room and tags bad
    // pipe numbers and unusable open lengths so the back only looks up state
    mcbp_front #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_BYTES (PIPE_BYTES)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pipe      (s_pipe),
        .s_length    (s_length),
        .s_data_in   (s_data_in),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_req       (q_req)
    );

    // two-entry queue keeps the request side moving while results stall
    mcbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (q_req),
        .pop      (head_pop),
        .head_req (head_req),
        .stat     (q_stat)
    );

    // back: one request per cycle into the result register unless results stall;
    // pops read the ring storage at the same edge so the byte lands with the result
    mcbp_back #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_BYTES (PIPE_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (~q_stat.empty),
        .head_req     (head_req),
        .head_pop     (head_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_fill_count (m_fill_count),
        .m_capacity   (m_capacity),
        .m_can_write  (m_can_write),
        .m_can_read   (m_can_read)
    );

    // checks

    // the front must never write into a full queue
    `MCBP_ASSERT_SAME(a_no_push_full, aclk, aresetn, q_push, !q_stat.full, "push into full queue")

    // a bad pipe reports no state at all
    `MCBP_ASSERT_SAME(a_bad_pipe_zero, aclk, aresetn,
        m_valid && (m_status == ST_BAD_PIPE),
        (m_fill_count == '0) && (m_capacity == '0) && !m_can_write && !m_can_read,
        "bad pipe result carries state")

    // a pipe never holds more than its capacity
    `MCBP_ASSERT_SAME(a_fill_le_cap, aclk, aresetn, m_valid,
        m_fill_count <= m_capacity, "fill count above capacity")

    // only a successful request may return a byte
    `MCBP_ASSERT_SAME(a_data_on_ok, aclk, aresetn, m_valid && (m_status != ST_OK),
        m_data_out == '0, "byte returned on failed request")

    // the queue drains into the back whenever the result side is free
    `MCBP_ASSERT_NEXT(a_drain, aclk, aresetn, !q_stat.empty && !m_valid, m_valid,
        "queued request not issued")

endmodule
